### rtl/core/hrbp_pkg.sv
// Shared constants, codes and character-class functions for the HTTP request byte parser.
package hrbp_pkg;

    // Width of the Content-Length accumulator and the body counter.
    localparam int LENGTH_BITS = 32;
    localparam int DECL_BITS   = 32;
    localparam int KEY_LEN     = 14;

    // Part tags
    localparam logic [3:0] PART_DELIM  = 4'd0;
    localparam logic [3:0] PART_METHOD = 4'd1;
    localparam logic [3:0] PART_PATH   = 4'd2;
    localparam logic [3:0] PART_PKEY   = 4'd3;
    localparam logic [3:0] PART_PVAL   = 4'd4;
    localparam logic [3:0] PART_PROTO  = 4'd5;
    localparam logic [3:0] PART_VER    = 4'd6;
    localparam logic [3:0] PART_HKEY   = 4'd7;
    localparam logic [3:0] PART_HVAL   = 4'd8;
    localparam logic [3:0] PART_BODY   = 4'd9;

    // Status codes
    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_COMPLETE   = 3'd1;
    localparam logic [2:0] ST_BAD_METHOD = 3'd2;
    localparam logic [2:0] ST_BAD_URL    = 3'd3;
    localparam logic [2:0] ST_BAD_PROTO  = 3'd4;
    localparam logic [2:0] ST_BAD_HEADER = 3'd5;
    localparam logic [2:0] ST_BAD_CRLF   = 3'd6;
    localparam logic [2:0] ST_INVALID    = 3'd7;

    // Header value scan steps
    localparam logic [3:0] SCAN_NONE  = 4'd0;
    localparam logic [3:0] SCAN_WS    = 4'd1;
    localparam logic [3:0] SCAN_SIGN  = 4'd2;
    localparam logic [3:0] SCAN_DIGIT = 4'd3;
    localparam logic [3:0] SCAN_STOP  = 4'd4;
    localparam logic [3:0] KEY_MISS   = 4'd15;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CTL   = 8'h1F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // "Content-Length"
    localparam logic [7:0] LEN_KEY [KEY_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
    };

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic url_bad(input logic [7:0] c);
        logic bad;
        case (c)
            8'h20, 8'h21, 8'h23, 8'h24, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B,
            8'h2C, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B,
            8'h27, 8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7C: bad = 1'b1;
            default: bad = (c <= CH_CTL) || (c == CH_DEL);
        endcase
        return bad;
    endfunction

    function automatic logic hkey_bad(input logic [7:0] c);
        logic bad;
        case (c)
            8'h20, 8'h2C, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h40, 8'h5C, 8'h5E,
            8'h60, 8'h7C: bad = 1'b1;
            default: bad = (c <= CH_CTL) || (c == CH_DEL);
        endcase
        return bad;
    endfunction

endpackage

### rtl/core/http_request_byte_parser.sv
// Streaming HTTP request parser: one byte in, one tagged word out per cycle while the output is not stalled.
// A word accepted at the input shows on the output in the next cycle, from the output register.
// Throughput: one word per cycle; the only register stage is the output register,
// and the input stalls only while that register holds a word the sink is stalling.
// Reset (rst_n low, asynchronous): parser goes to the start state, length and body
// counters clear, the output register empties.
module http_request_byte_parser
    import hrbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 start_new,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           echo_byte,
    output logic [3:0]           part,
    output logic                 field_start,
    output logic [2:0]           status,
    output logic [DECL_BITS-1:0] declared_length
);

    // Grammar position. Codes past PH_INVALID have no meaning and fall to invalid.
    typedef enum logic [4:0] {
        PH_START, PH_METHOD, PH_PRE_URL, PH_URL, PH_PRE_PKEY, PH_PKEY,
        PH_PRE_PVAL, PH_PVAL, PH_PRE_PROTO, PH_PROTO, PH_PRE_VER, PH_VER,
        PH_CR, PH_CRLF, PH_HKEY, PH_PRE_HVAL, PH_HVAL, PH_CRLFCR, PH_BODY,
        PH_COMPLETE, PH_BAD_METHOD, PH_BAD_URL, PH_BAD_PROTO, PH_BAD_HEADER,
        PH_BAD_CRLF, PH_INVALID
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic [3:0]             kmi_reg, kmi_next;      // key match index / value scan step
    logic                   key_len_reg, key_len_next;
    logic                   len_seen_reg, len_seen_next;
    logic                   len_neg_reg, len_neg_next;
    logic [LENGTH_BITS-1:0] len_val_reg, len_val_next;
    logic [LENGTH_BITS-1:0] body_left_reg, body_left_next;

    // Output register
    logic                   out_valid_reg;
    logic [7:0]             echo_reg;
    logic [3:0]             part_reg, part_next;
    logic                   fs_reg, fs_next;
    logic [2:0]             status_reg, status_next;
    logic [DECL_BITS-1:0]   decl_reg, decl_next;

    logic                   in_acc;
    logic [7:0]             c;

    // Working copies after the optional restart
    phase_t                 ph_cur;
    logic [3:0]             kmi_cur;
    logic                   key_len_cur;
    logic                   len_seen_cur;
    logic                   len_neg_cur;
    logic [LENGTH_BITS-1:0] len_val_cur;
    logic [LENGTH_BITS-1:0] body_left_cur;

    // value * 10 + digit, four guard bits show overflow
    logic [LENGTH_BITS+3:0] len_mul;
    logic                   len_ovf;
    logic                   restart;

    logic [LENGTH_BITS+DECL_BITS-1:0] len_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign c        = data_byte;

    // A completed request restarts on the next word, same as start_new.
    assign restart = start_new || (phase_reg == PH_COMPLETE);

    always_comb
    begin
        ph_cur        = restart ? PH_START : phase_reg;
        kmi_cur       = restart ? SCAN_NONE : kmi_reg;
        key_len_cur   = restart ? 1'b0 : key_len_reg;
        len_seen_cur  = restart ? 1'b0 : len_seen_reg;
        len_neg_cur   = restart ? 1'b0 : len_neg_reg;
        len_val_cur   = restart ? '0 : len_val_reg;
        body_left_cur = restart ? '0 : body_left_reg;
    end

    assign len_mul = ({4'b0, len_val_cur} << 3) + ({4'b0, len_val_cur} << 1)
                   + (LENGTH_BITS+4)'(c[3:0]);
    assign len_ovf = |len_mul[LENGTH_BITS+3:LENGTH_BITS];

    // Next-state and result logic
    always_comb
    begin
        phase_next     = ph_cur;
        kmi_next       = kmi_cur;
        key_len_next   = key_len_cur;
        len_seen_next  = len_seen_cur;
        len_neg_next   = len_neg_cur;
        len_val_next   = len_val_cur;
        body_left_next = body_left_cur;
        part_next      = PART_DELIM;
        fs_next        = 1'b0;

        case (ph_cur)
            PH_START:
            begin
                if (is_blank(c) || c == CH_CR || c == CH_LF) begin
                    // leading junk skipped
                end else if (is_upper(c)) begin
                    phase_next = PH_METHOD;
                    part_next  = PART_METHOD;
                    fs_next    = 1'b1;
                end else begin
                    phase_next = PH_BAD_METHOD;
                end
            end
            PH_METHOD:
            begin
                if (is_upper(c))       part_next  = PART_METHOD;
                else if (is_blank(c))  phase_next = PH_PRE_URL;
                else                   phase_next = PH_BAD_METHOD;
            end
            PH_PRE_URL:
            begin
                if (c == CH_SLASH) begin
                    phase_next = PH_URL;
                    part_next  = PART_PATH;
                    fs_next    = 1'b1;
                end else begin
                    phase_next = PH_BAD_URL;
                end
            end
            PH_URL:
            begin
                if (c == CH_QUEST)     phase_next = PH_PRE_PKEY;
                else if (is_blank(c))  phase_next = PH_PRE_PROTO;
                else if (url_bad(c))   phase_next = PH_BAD_URL;
                else                   part_next  = PART_PATH;
            end
            PH_PRE_PKEY:
            begin
                if (url_bad(c)) begin
                    phase_next = PH_BAD_URL;
                end else begin
                    phase_next = PH_PKEY;
                    part_next  = PART_PKEY;
                    fs_next    = 1'b1;
                end
            end
            PH_PKEY:
            begin
                if (c == CH_EQ)        phase_next = PH_PRE_PVAL;
                else if (url_bad(c))   phase_next = PH_BAD_URL;
                else                   part_next  = PART_PKEY;
            end
            PH_PRE_PVAL:
            begin
                if (url_bad(c)) begin
                    phase_next = PH_BAD_URL;
                end else begin
                    phase_next = PH_PVAL;
                    part_next  = PART_PVAL;
                    fs_next    = 1'b1;
                end
            end
            PH_PVAL:
            begin
                if (c == CH_AMP)       phase_next = PH_PRE_PKEY;
                else if (is_blank(c))  phase_next = PH_PRE_PROTO;
                else if (url_bad(c))   phase_next = PH_BAD_URL;
                else                   part_next  = PART_PVAL;
            end
            PH_PRE_PROTO:
            begin
                if (is_upper(c)) begin
                    phase_next = PH_PROTO;
                    part_next  = PART_PROTO;
                    fs_next    = 1'b1;
                end else begin
                    phase_next = PH_BAD_PROTO;
                end
            end
            PH_PROTO:
            begin
                if (is_upper(c))         part_next  = PART_PROTO;
                else if (c == CH_SLASH)  phase_next = PH_PRE_VER;
                else                     phase_next = PH_BAD_PROTO;
            end
            PH_PRE_VER:
            begin
                if (is_digit(c)) begin
                    phase_next = PH_VER;
                    part_next  = PART_VER;
                    fs_next    = 1'b1;
                end else begin
                    phase_next = PH_BAD_PROTO;
                end
            end
            PH_VER:
            begin
                if (c == CH_CR)                        phase_next = PH_CR;
                else if (is_digit(c) || c == CH_DOT)   part_next  = PART_VER;
                else                                   phase_next = PH_BAD_PROTO;
            end
            PH_CR:
            begin
                phase_next = (c == CH_LF) ? PH_CRLF : PH_BAD_CRLF;
            end
            PH_CRLF:
            begin
                if (c == CH_CR) begin
                    phase_next = PH_CRLFCR;
                end else if (hkey_bad(c)) begin
                    phase_next = PH_BAD_HEADER;
                end else begin
                    phase_next = PH_HKEY;
                    part_next  = PART_HKEY;
                    fs_next    = 1'b1;
                    kmi_next   = (c == LEN_KEY[0]) ? 4'd1 : KEY_MISS;
                end
            end
            PH_HKEY:
            begin
                if (c == CH_COLON) begin
                    phase_next   = PH_PRE_HVAL;
                    key_len_next = (kmi_cur == 4'(KEY_LEN));
                end else if (hkey_bad(c)) begin
                    phase_next = PH_BAD_HEADER;
                end else begin
                    part_next = PART_HKEY;
                    if (kmi_cur < 4'(KEY_LEN) && c == LEN_KEY[kmi_cur])
                        kmi_next = kmi_cur + 4'd1;
                    else
                        kmi_next = KEY_MISS;
                end
            end
            PH_PRE_HVAL:
            begin
                if (!is_blank(c)) begin
                    phase_next = PH_BAD_HEADER;
                end else begin
                    phase_next = PH_HVAL;
                    kmi_next   = SCAN_NONE;
                    if (key_len_cur) begin
                        len_seen_next = 1'b1;
                        len_neg_next  = 1'b0;
                        len_val_next  = '0;
                    end
                end
            end
            PH_HVAL:
            begin
                if (c == CH_CR) begin
                    phase_next   = PH_CR;
                    key_len_next = 1'b0;
                end else begin
                    part_next = PART_HVAL;
                    fs_next   = (kmi_cur == SCAN_NONE);
                    if (!key_len_cur) begin
                        kmi_next = SCAN_STOP;
                    end else if (kmi_cur <= SCAN_WS
                                 && (c == CH_SP || (c >= CH_TAB && c <= CH_FF))) begin
                        kmi_next = SCAN_WS;
                    end else if (kmi_cur <= SCAN_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                        if (c == CH_MINUS)
                            len_neg_next = 1'b1;
                        kmi_next = SCAN_SIGN;
                    end else if (kmi_cur <= SCAN_DIGIT && is_digit(c)) begin
                        if (len_ovf) begin
                            // saturate and poison the length
                            len_val_next = LEN_MAX;
                            len_neg_next = 1'b1;
                            kmi_next     = SCAN_STOP;
                        end else begin
                            len_val_next = len_mul[LENGTH_BITS-1:0];
                            kmi_next     = SCAN_DIGIT;
                        end
                    end else begin
                        kmi_next = SCAN_STOP;
                    end
                end
            end
            PH_CRLFCR:
            begin
                if (c != CH_LF) begin
                    phase_next = PH_BAD_CRLF;
                end else if (len_seen_cur && len_neg_cur && len_val_cur != '0) begin
                    phase_next = PH_BAD_HEADER;
                end else if (!len_seen_cur || len_val_cur == '0) begin
                    phase_next = PH_COMPLETE;
                end else begin
                    phase_next     = PH_BODY;
                    body_left_next = len_val_cur;
                end
            end
            PH_BODY:
            begin
                part_next = PART_BODY;
                fs_next   = (body_left_cur == len_val_cur);
                if (body_left_cur != '0)
                    body_left_next = body_left_cur - LENGTH_BITS'(1);
                if (body_left_next == '0)
                    phase_next = PH_COMPLETE;
            end
            PH_COMPLETE, PH_BAD_METHOD, PH_BAD_URL, PH_BAD_PROTO,
            PH_BAD_HEADER, PH_BAD_CRLF, PH_INVALID:
            begin
                // sticky
            end
            default:
            begin
                phase_next = PH_INVALID;
            end
        endcase
    end

    // Status after this word
    always_comb
    begin
        case (phase_next)
            PH_COMPLETE:   status_next = ST_COMPLETE;
            PH_BAD_METHOD: status_next = ST_BAD_METHOD;
            PH_BAD_URL:    status_next = ST_BAD_URL;
            PH_BAD_PROTO:  status_next = ST_BAD_PROTO;
            PH_BAD_HEADER: status_next = ST_BAD_HEADER;
            PH_BAD_CRLF:   status_next = ST_BAD_CRLF;
            PH_INVALID:    status_next = ST_INVALID;
            default:       status_next = (phase_next < PH_COMPLETE) ? ST_BUSY : ST_INVALID;
        endcase
    end

    // Reported length saturates at the output width.
    assign len_ext   = {{DECL_BITS{1'b0}}, len_val_next};
    assign decl_next = (|len_ext[LENGTH_BITS+DECL_BITS-1:DECL_BITS])
                     ? {DECL_BITS{1'b1}} : len_ext[DECL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_START;
            kmi_reg       <= SCAN_NONE;
            key_len_reg   <= 1'b0;
            len_seen_reg  <= 1'b0;
            len_neg_reg   <= 1'b0;
            len_val_reg   <= '0;
            body_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                phase_reg     <= phase_next;
                kmi_reg       <= kmi_next;
                key_len_reg   <= key_len_next;
                len_seen_reg  <= len_seen_next;
                len_neg_reg   <= len_neg_next;
                len_val_reg   <= len_val_next;
                body_left_reg <= body_left_next;
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            echo_reg   <= c;
            part_reg   <= part_next;
            fs_reg     <= fs_next;
            status_reg <= status_next;
            decl_reg   <= decl_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign echo_byte       = echo_reg;
    assign part            = part_reg;
    assign field_start     = fs_reg;
    assign status          = status_reg;
    assign declared_length = decl_reg;

endmodule
